@@ src/bbc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the bracket balance checker.
// No dependencies; every other file but bbc_ram imports this package.
package bbc_pkg;

   // Default stack depth and fixed field widths
   localparam int STACK_DEPTH_DEF = 64;
   localparam int CHAR_W          = 8;
   localparam int STATUS_W        = 3;
   localparam int OPEN_DEPTH_W    = 7;
   localparam int KIND_W          = 2;
   localparam int OPEN_DEPTH_MAX  = 127;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Bracket characters
   localparam logic [CHAR_W-1:0] CH_PAREN_OPEN   = 8'h28;
   localparam logic [CHAR_W-1:0] CH_PAREN_CLOSE  = 8'h29;
   localparam logic [CHAR_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_CURLY_OPEN   = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_CURLY_CLOSE  = 8'h7D;

   // Bracket kinds as stored on the stack
   localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EARLY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SURPLUS  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
   localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BALANCED = 3'd6;

   // Classified operation
   typedef enum logic [1:0] {
      OP_NONE,
      OP_OPEN,
      OP_CLOSE
   } op_kind_type;

   typedef struct packed {
      op_kind_type       op;
      logic [KIND_W-1:0] kind;
      logic              eos;
   } bbc_op_type;

   // Channel payloads
   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [OPEN_DEPTH_W-1:0] open_depth;
      logic                    last;
   } rsp_payload_type;

endpackage

@@ src/bbc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bbc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input transactions and classifies each character.
// Depends on bbc_pkg.
module bbc_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bbc_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output bbc_pkg::bbc_op_type      push_op
);
   import bbc_pkg::*;

   // Take a transaction whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Decode the character into open, close or nothing plus its kind
   always_comb begin
      push_op.op   = OP_NONE;
      push_op.kind = KIND_PAREN;
      push_op.eos  = req_payload.end_of_string;
      case (req_payload.char_in)
         CH_PAREN_OPEN: begin
            push_op.op   = OP_OPEN;
            push_op.kind = KIND_PAREN;
         end
         CH_SQUARE_OPEN: begin
            push_op.op   = OP_OPEN;
            push_op.kind = KIND_SQUARE;
         end
         CH_CURLY_OPEN: begin
            push_op.op   = OP_OPEN;
            push_op.kind = KIND_CURLY;
         end
         CH_PAREN_CLOSE: begin
            push_op.op   = OP_CLOSE;
            push_op.kind = KIND_PAREN;
         end
         CH_SQUARE_CLOSE: begin
            push_op.op   = OP_CLOSE;
            push_op.kind = KIND_SQUARE;
         end
         CH_CURLY_CLOSE: begin
            push_op.op   = OP_CLOSE;
            push_op.kind = KIND_CURLY;
         end
         default: begin
            push_op.op   = OP_NONE;
            push_op.kind = KIND_PAREN;
         end
      endcase
   end

endmodule

@@ src/bbc_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified operations between front and back.
// Depends on bbc_pkg.
module bbc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bbc_pkg::bbc_op_type push_op,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output bbc_pkg::bbc_op_type pop_op
);
   import bbc_pkg::*;

   bbc_op_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed operation
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ src/bbc_back.sv @@
`timescale 1ns / 1ps
// Back end: runs the bracket stack, latches errors and registers results.
// Depends on bbc_pkg and bbc_ram.
module bbc_back #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   input  bbc_pkg::bbc_op_type      op,
   output logic                     op_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bbc_pkg::rsp_payload_type rsp_payload
);
   import bbc_pkg::*;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);

   logic [SP_W-1:0]     sp_ff, sp_in, sp_step;
   logic [KIND_W-1:0]   top_ff, top_in;
   logic                opens_ff, opens_in;
   logic [STATUS_W-1:0] err_ff, err_in, err_step;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                fire;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [SP_W-1:0]     rd_sp;
   logic [IDX_W-1:0]    rd_addr;
   logic [KIND_W-1:0]   below;

   // Stack entries; the entry under the top is prefetched every cycle
   bbc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (op.kind),
      .rd_addr (rd_addr),
      .rd_data (below)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = op_valid && out_free;
   assign op_pop   = fire;
   assign wr_addr  = sp_ff[IDX_W-1:0];

   // Push, pop or latch an error for one transaction
   always_comb begin
      sp_step  = sp_ff;
      top_in   = top_ff;
      opens_in = opens_ff;
      err_step = err_ff;
      wr_en    = 1'b0;
      if (fire && err_ff == ST_OK) begin
         case (op.op)
            OP_OPEN: begin
               if (sp_ff == SP_W'(STACK_DEPTH)) begin
                  err_step = ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  top_in   = op.kind;
                  sp_step  = sp_ff + 1'b1;
                  opens_in = 1'b1;
               end
            end
            OP_CLOSE: begin
               if (sp_ff == '0) begin
                  err_step = opens_ff ? ST_SURPLUS : ST_EARLY;
               end else if (top_ff == op.kind) begin
                  sp_step = sp_ff - 1'b1;
                  top_in  = below;
               end else begin
                  err_step = ST_MISMATCH;
               end
            end
            default: begin
               sp_step = sp_ff;
            end
         endcase
      end
      // Forget earlier opens once the string ends
      if (fire && op.eos) begin
         opens_in = 1'b0;
      end
   end

   // Build the result and clear the string state at its last character
   always_comb begin
      rsp_data_in.last = op.eos;
      if (32'(sp_step) > OPEN_DEPTH_MAX) begin
         rsp_data_in.open_depth = OPEN_DEPTH_W'(OPEN_DEPTH_MAX);
      end else begin
         rsp_data_in.open_depth = OPEN_DEPTH_W'(sp_step);
      end
      if (err_step != ST_OK) begin
         rsp_data_in.status = err_step;
      end else if (!op.eos) begin
         rsp_data_in.status = ST_OK;
      end else if (sp_step != '0) begin
         rsp_data_in.status = ST_UNCLOSED;
      end else begin
         rsp_data_in.status = ST_BALANCED;
      end

      sp_in  = sp_step;
      err_in = err_step;
      if (fire && op.eos) begin
         sp_in  = '0;
         err_in = ST_OK;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Prefetch the entry that will sit under the next top
   assign rd_sp   = sp_in - SP_W'(2);
   assign rd_addr = rd_sp[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         opens_ff     <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         opens_ff     <= opens_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold top of stack and result payload
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

@@ src/bracket_balance_checker_top.sv @@
`timescale 1ns / 1ps
// Bracket balance checker, one character per transaction, one result each.
// It takes one character per clock while the queue has room. Each result
// passes a queue slot, then the stack engine's result register, which
// drives the output. The sustained rate is one item per cycle while the
// output is not stalled, set by the stack engine, which does one push or
// pop a cycle with the top of stack in a register and the entry below it
// prefetched from the stack RAM's single read port. A two-entry queue
// separates the classifying front end from the stack engine, and lets new
// characters be taken while a result waits. No clearing pass follows reset.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back and bbc_ram.
module bracket_balance_checker_top #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bbc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bbc_pkg::rsp_payload_type rsp_payload
);
   import bbc_pkg::*;

   logic       queue_full;
   logic       push;
   bbc_op_type push_op;
   logic       pop;
   logic       pop_valid;
   bbc_op_type pop_op;

   // Classify incoming characters
   bbc_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_op     (push_op)
   );

   // Decouple front and back
   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_op    (pop_op)
   );

   // Run the stack and deliver results
   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (pop_valid),
      .op          (pop_op),
      .op_pop      (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/bracket_balance_checker_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bracket_balance_checker_top: directed and random strings
// of brackets and other bytes, each result checked against a local bracket predictor.
// Depends on bbc_pkg and the bracket_balance_checker_top RTL.
module bracket_balance_checker_top_test;
   import bbc_pkg::*;

   localparam int DEPTH        = STACK_DEPTH_DEF;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_LONG
   } stall_mode_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   bracket_balance_checker_top #(.STACK_DEPTH(DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Predictor state: bracket stack, depth, opens-seen flag and latched error
   logic [KIND_W-1:0]   pred_stack [DEPTH];
   int unsigned         pred_depth  = 0;
   logic                pred_opened = 1'b0;
   logic [STATUS_W-1:0] pred_error  = ST_OK;

   rsp_payload_type     pending_results [$];
   logic [CHAR_W-1:0]   string_buf [$];

   int sent_chars     = 0;
   int sent_strings   = 0;
   int burst_left     = 0;
   int gap_max        = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int end_counts [8];

   // Clock: 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("bracket_balance_checker_top_test NOT OK");
      $finish;
   end

   function automatic logic [CHAR_W-1:0] open_char(input logic [KIND_W-1:0] kind);
      case (kind)
         KIND_PAREN:  return CH_PAREN_OPEN;
         KIND_SQUARE: return CH_SQUARE_OPEN;
         default:     return CH_CURLY_OPEN;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] close_char(input logic [KIND_W-1:0] kind);
      case (kind)
         KIND_PAREN:  return CH_PAREN_CLOSE;
         KIND_SQUARE: return CH_SQUARE_CLOSE;
         default:     return CH_CURLY_CLOSE;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] random_kind();
      return KIND_W'($urandom_range(0, 2));
   endfunction

   function automatic logic [CHAR_W-1:0] random_bracket();
      if ($urandom_range(0, 1) == 0)
         return open_char(random_kind());
      return close_char(random_kind());
   endfunction

   // Pick a random byte that is not one of the six brackets
   function automatic logic [CHAR_W-1:0] noise_char();
      logic [CHAR_W-1:0] ch;
      do
         ch = CHAR_W'($urandom_range(0, 255));
      while (ch == CH_PAREN_OPEN || ch == CH_PAREN_CLOSE || ch == CH_SQUARE_OPEN ||
             ch == CH_SQUARE_CLOSE || ch == CH_CURLY_OPEN || ch == CH_CURLY_CLOSE);
      return ch;
   endfunction

   // Advance the predictor by one character and return the expected result
   function automatic rsp_payload_type predict_result(input logic [CHAR_W-1:0] ch,
                                                      input logic eos);
      rsp_payload_type   res;
      logic              is_open;
      logic              is_close;
      logic [KIND_W-1:0] kind;
      is_open  = 1'b0;
      is_close = 1'b0;
      kind     = KIND_PAREN;
      case (ch)
         CH_PAREN_OPEN: begin
            is_open = 1'b1;
            kind    = KIND_PAREN;
         end
         CH_SQUARE_OPEN: begin
            is_open = 1'b1;
            kind    = KIND_SQUARE;
         end
         CH_CURLY_OPEN: begin
            is_open = 1'b1;
            kind    = KIND_CURLY;
         end
         CH_PAREN_CLOSE: begin
            is_close = 1'b1;
            kind     = KIND_PAREN;
         end
         CH_SQUARE_CLOSE: begin
            is_close = 1'b1;
            kind     = KIND_SQUARE;
         end
         CH_CURLY_CLOSE: begin
            is_close = 1'b1;
            kind     = KIND_CURLY;
         end
         default: begin
         end
      endcase

      // Once an error is latched the stack stays frozen until end of string
      if (pred_error == ST_OK) begin
         if (is_open) begin
            if (pred_depth >= DEPTH) begin
               pred_error = ST_OVERFLOW;
            end else begin
               pred_stack[pred_depth] = kind;
               pred_depth++;
               pred_opened = 1'b1;
            end
         end else if (is_close) begin
            if (pred_depth == 0)
               pred_error = pred_opened ? ST_SURPLUS : ST_EARLY;
            else if (pred_stack[pred_depth - 1] == kind)
               pred_depth--;
            else
               pred_error = ST_MISMATCH;
         end
      end

      res.open_depth = (pred_depth > OPEN_DEPTH_MAX) ? OPEN_DEPTH_W'(OPEN_DEPTH_MAX)
                                                     : OPEN_DEPTH_W'(pred_depth);
      if (pred_error != ST_OK)
         res.status = pred_error;
      else if (!eos)
         res.status = ST_OK;
      else if (pred_depth != 0)
         res.status = ST_UNCLOSED;
      else
         res.status = ST_BALANCED;
      res.last = eos;

      // Clear for the next string
      if (eos) begin
         pred_depth  = 0;
         pred_opened = 1'b0;
         pred_error  = ST_OK;
      end
      return res;
   endfunction

   // Send one character; hold it until accepted, then idle between bursts
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eos);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= '{char_in: ch, end_of_string: eos};
      do
         @(posedge clock);
      while (req_stall);
      pending_results.push_back(predict_result(ch, eos));
      sent_chars++;
      if (eos)
         sent_strings++;
      if (gap_max > 0) begin
         if (burst_left > 0)
            burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 32);
         end
      end
   endtask

   // Send the buffered string, marking its last character
   task automatic send_buffer();
      for (int i = 0; i < string_buf.size(); i++)
         send_char(string_buf[i], i == string_buf.size() - 1);
   endtask

   task automatic send_text(input string text);
      string_buf.delete();
      for (int i = 0; i < text.len(); i++)
         string_buf.push_back(text[i]);
      send_buffer();
   endtask

   // Build a well-formed string of n characters with nesting up to max_depth
   task automatic build_nested(input int n, input int max_depth, input int noise_pct,
                               input int open_pct);
      logic [KIND_W-1:0] open_kinds [$];
      logic [KIND_W-1:0] kind;
      int                rem;
      string_buf.delete();
      for (int i = 0; i < n; i++) begin
         rem = n - i;
         if (open_kinds.size() >= rem) begin
            kind = open_kinds.pop_back();
            string_buf.push_back(close_char(kind));
         end else if ($urandom_range(0, 99) < noise_pct) begin
            string_buf.push_back(noise_char());
         end else if (open_kinds.size() + 2 <= rem && open_kinds.size() < max_depth &&
                      (open_kinds.size() == 0 || $urandom_range(0, 99) < open_pct)) begin
            kind = random_kind();
            open_kinds.push_back(kind);
            string_buf.push_back(open_char(kind));
         end else if (open_kinds.size() > 0) begin
            kind = open_kinds.pop_back();
            string_buf.push_back(close_char(kind));
         end else begin
            string_buf.push_back(noise_char());
         end
      end
   endtask

   // Break a buffered string: replace, insert or cut at a random position
   task automatic corrupt_buffer();
      int pos;
      pos = $urandom_range(0, string_buf.size() - 1);
      case ($urandom_range(0, 3))
         0: string_buf[pos] = random_bracket();
         1: string_buf.insert(pos, close_char(random_kind()));
         2: begin
            while (string_buf.size() > pos + 1)
               void'(string_buf.pop_back());
         end
         default: string_buf[pos] = CHAR_W'($urandom_range(0, 255));
      endcase
   endtask

   // Field extremes, each error kind but overflow, latched errors and plain balance
   task automatic test_directed_cases();
      gap_max = 3;
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_text(")");
      send_text("())x");
      send_text("(]");
      send_text("[{");
      send_text("([]{})");
      send_text("}(");
   endtask

   // Fill the stack to its limit and drain it, fill it unclosed, then push one past the limit
   task automatic test_stack_limits();
      logic [KIND_W-1:0] kinds [$];
      gap_max = 0;
      string_buf.delete();
      for (int i = 0; i < DEPTH; i++) begin
         kinds.push_back(random_kind());
         string_buf.push_back(open_char(kinds[i]));
      end
      for (int i = DEPTH - 1; i >= 0; i--)
         string_buf.push_back(close_char(kinds[i]));
      send_buffer();

      string_buf.delete();
      for (int i = 0; i < DEPTH; i++)
         string_buf.push_back(open_char(random_kind()));
      send_buffer();

      string_buf.delete();
      for (int i = 0; i < DEPTH; i++)
         string_buf.push_back(open_char(random_kind()));
      string_buf.push_back(CH_CURLY_OPEN);
      string_buf.push_back(CH_PAREN_CLOSE);
      string_buf.push_back(8'h41);
      send_buffer();
   endtask

   // Mostly well-formed strings, some broken ones, some raw bytes
   task automatic test_random_strings(input int items, input int gap_limit);
      int stop_at;
      int pick;
      int len;
      int depth_cap;
      int open_pct;
      gap_max = gap_limit;
      stop_at = sent_chars + items;
      while (sent_chars < stop_at) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) begin
            len       = $urandom_range(60, 140);
            depth_cap = ($urandom_range(0, 1) == 0) ? DEPTH : DEPTH + 6;
            open_pct  = 75;
         end else begin
            len       = $urandom_range(1, 16);
            depth_cap = DEPTH;
            open_pct  = 50;
         end
         if (pick < 10) begin
            string_buf.delete();
            for (int i = 0; i < $urandom_range(1, 12); i++)
               string_buf.push_back(CHAR_W'($urandom_range(0, 255)));
         end else begin
            build_nested(len, depth_cap, 15, open_pct);
            if (pick < 30)
               corrupt_buffer();
         end
         send_buffer();
      end
   endtask

   // Receiver: stall on a pattern whose mode changes at random intervals
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             stall_run  = 0;
   logic           stall_on   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 300);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: begin
               if (stall_run == 0) begin
                  stall_run = $urandom_range(1, 12);
                  stall_on  = !stall_on;
               end
               stall_run--;
               rsp_stall <= stall_on;
            end
         endcase
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d depth=%0d last=%0d",
                                      rsp_payload.status, rsp_payload.open_depth,
                                      rsp_payload.last));
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (want.last)
               end_counts[want.status]++;
            if (rsp_payload.status !== want.status ||
                rsp_payload.open_depth !== want.open_depth ||
                rsp_payload.last !== want.last)
               report_mismatch($sformatf(
                  "result %0d: expected status=%0d depth=%0d last=%0d, got %0d %0d %0d",
                  checked_count, want.status, want.open_depth, want.last,
                  rsp_payload.status, rsp_payload.open_depth, rsp_payload.last));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_stack_limits();
      test_random_strings(700, 6);
      test_random_strings(300, 0);
      test_random_strings(350, 2);
      req_valid <= 1'b0;

      // Drain outstanding results, then allow the pipeline to settle
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d characters in %0d strings, %0d results checked, %0d mismatches",
               sent_chars, sent_strings, checked_count, mismatch_count);
      $display("endings: balanced %0d unclosed %0d early %0d surplus %0d mismatch %0d overflow %0d",
               end_counts[ST_BALANCED], end_counts[ST_UNCLOSED], end_counts[ST_EARLY],
               end_counts[ST_SURPLUS], end_counts[ST_MISMATCH], end_counts[ST_OVERFLOW]);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("bracket_balance_checker_top_test OK");
      else
         $display("bracket_balance_checker_top_test NOT OK");
      $finish;
   end

endmodule

@@ bracket_balance_checker_top.f @@
src/bbc_pkg.sv
src/bbc_ram.sv
src/bbc_front.sv
src/bbc_queue.sv
src/bbc_back.sv
src/bracket_balance_checker_top.sv
sim/bracket_balance_checker_top_test.sv
